>>> design/skvm_pkg.sv
// shared types and constants of the sorted key-value map
`default_nettype none

package skvm_pkg;

   // storage geometry
   localparam int CAPACITY   = 1024;
   localparam int KEY_W      = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE = 32;
   localparam int GROUPS     = CAPACITY / GROUP_SIZE;

   // operation codes of a request word
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_FIND   = 2'd2;

   // status codes of a response word
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DUP     = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   localparam logic [KEY_W-1:0] NONE_VALUE = '1;

   typedef logic signed [KEY_W-1:0] word_type;

   // what the row of cells does to its stored entries
   typedef enum logic [1:0] {
      SHIFT_HOLD   = 2'd0,
      SHIFT_INSERT = 2'd1,
      SHIFT_DELETE = 2'd2
   } shift_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      compare;
      shift_type shift;
      word_type  key;
      word_type  value;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> design/skvm_if.sv
// request and response channel interfaces of the sorted key-value map
`default_nettype none

interface skvm_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic signed [31:0]       lookup_key;
   logic signed [31:0]       item_value;

   modport source (output valid, output kind, output lookup_key, output item_value,
                   input ready);
   modport sink   (input valid, input kind, input lookup_key, input item_value,
                   output ready);
endinterface

interface skvm_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [31:0]       found_value;

   modport source (output valid, output status, output found_value, input ready);
   modport sink   (input valid, input status, input found_value, output ready);
endinterface

`default_nettype wire

>>> design/sorted_key_value_map_unit.sv
// Sorted key-value map: an ordered row of cells with a registered match tree.
//
// Requests arrive on req_chan (insert, delete or find of a signed 32-bit key);
// every request gives exactly one word on rsp_chan with a status and a value.
// The map is kept as a row of CAPACITY cells holding the entries in ascending
// key order, packed from cell zero; the entry count marks which cells are live.
// A request passes the compare registers of every cell, then the two registered
// levels of the 32-wide match tree, and then the decision step, which takes the
// decision, shifts the cells and loads the output register once it is free. One
// request is handled at a time: a new request is taken only after the last one
// has left its decision step.
// Reset sets the entry count to zero, which empties the map at once; there is
// no clearing pass. When the receiver stalls, the response word holds in the
// output register; the next request is still accepted and worked on, and it
// waits at its decision step until the output register is free.
`default_nettype none

module sorted_key_value_map_unit (
   input  logic       clock,
   input  logic       reset,
   skvm_req_if.sink   req_chan,
   skvm_rsp_if.source rsp_chan
);
   import skvm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_GRP  = 5'b00100,
      S_SUM  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                           state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [1:0]                          kind_ff;
   word_type                            key_ff;
   word_type                            value_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]                    rsp_value_ff, rsp_value_in;
   logic                                hit_ff, hit_in;
   logic [KEY_W-1:0]                    found_ff, found_in;
   logic                                load;
   cell_cmd_type                        cmd;

   logic [CAPACITY-1:0][KEY_W-1:0]      cell_key;
   logic [CAPACITY-1:0][KEY_W-1:0]      cell_value;
   logic [CAPACITY-1:0]                 cell_lt;
   logic [CAPACITY-1:0]                 cell_eq;
   logic [GROUPS-1:0]                   group_hit;
   logic [GROUPS-1:0][KEY_W-1:0]        group_value;

   // handshake
   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_value = rsp_value_ff;

   // result may leave the decision step once the output register is free
   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic     prev_lt;
      word_type prev_key, prev_value, next_key, next_value;
      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign prev_key   = cell_key[i];
         assign prev_value = cell_value[i];
      end else begin : g_inner
         assign prev_lt    = cell_lt[i-1];
         assign prev_key   = cell_key[i-1];
         assign prev_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_key   = cell_key[i];
         assign next_value = cell_value[i];
      end else begin : g_body
         assign next_key   = cell_key[i+1];
         assign next_value = cell_value[i+1];
      end
      skvm_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_valid (count_ff > CNT_W'(i)),
         .prev_lt    (prev_lt),
         .prev_key   (prev_key),
         .prev_value (prev_value),
         .next_key   (next_key),
         .next_value (next_value),
         .key_ff     (cell_key[i]),
         .value_ff   (cell_value[i]),
         .lt_ff      (cell_lt[i]),
         .eq_ff      (cell_eq[i])
      );
   end

   // first tree level
   for (genvar g = 0; g < GROUPS; g++) begin : g_group
      skvm_group u_group (
         .clock    (clock),
         .eq       (cell_eq[g*GROUP_SIZE +: GROUP_SIZE]),
         .values   (cell_value[g*GROUP_SIZE +: GROUP_SIZE]),
         .hit_ff   (group_hit[g]),
         .value_ff (group_value[g])
      );
   end

   // second tree level
   always_comb begin
      hit_in   = 1'b0;
      found_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         hit_in   = hit_in | group_hit[g];
         found_in = found_in | (group_value[g] & {KEY_W{group_hit[g]}});
      end
   end

   // sequencing, decision and cell command
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      cmd.compare   = 1'b0;
      cmd.shift     = SHIFT_HOLD;
      cmd.key       = key_ff;
      cmd.value     = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_GRP;
         end
         S_GRP: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = NONE_VALUE;
               rsp_status_in = STATUS_OK;
               case (kind_ff)
                  KIND_INSERT: begin
                     if (hit_ff) begin
                        rsp_status_in = STATUS_DUP;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.shift = SHIFT_INSERT;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  KIND_DELETE: begin
                     if (hit_ff) begin
                        cmd.shift = SHIFT_DELETE;
                        count_in  = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = STATUS_MISSING;
                     end
                  end
                  default: begin
                     // find, and the unused code behaves the same
                     if (hit_ff) begin
                        rsp_value_in = found_ff;
                     end else begin
                        rsp_status_in = STATUS_MISSING;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         kind_ff  <= req_chan.kind;
         key_ff   <= req_chan.lookup_key;
         value_ff <= req_chan.item_value;
      end
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_CMP))
      else $error("accepted request did not start a compare");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response word appeared outside the decision step");

   a_value_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |-> (rsp_value_ff == NONE_VALUE))
      else $error("failed request carries a value");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(load))
      else $error("entry count changed outside a decision");

endmodule

`default_nettype wire

>>> design/skvm_cell.sv
// one storage cell of the sorted row: key, value, compare flags, neighbor shift
`default_nettype none

module skvm_cell (
   input  logic                  clock,
   input  skvm_pkg::cell_cmd_type cmd,
   input  logic                  cell_valid,
   input  logic                  prev_lt,
   input  skvm_pkg::word_type    prev_key,
   input  skvm_pkg::word_type    prev_value,
   input  skvm_pkg::word_type    next_key,
   input  skvm_pkg::word_type    next_value,
   output skvm_pkg::word_type    key_ff,
   output skvm_pkg::word_type    value_ff,
   output logic                  lt_ff,
   output logic                  eq_ff
);
   import skvm_pkg::*;

   word_type key_in;
   word_type value_in;
   logic     lt_in;
   logic     eq_in;

   // compare against the broadcast key, then shift with the neighbors
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (cmd.compare) begin
         lt_in = cell_valid && (key_ff < cmd.key);
         eq_in = cell_valid && (key_ff == cmd.key);
      end
      case (cmd.shift)
         SHIFT_INSERT: begin
            // cells above the new key move up one place
            if (!lt_ff) begin
               if (prev_lt) begin
                  key_in   = cmd.key;
                  value_in = cmd.value;
               end else begin
                  key_in   = prev_key;
                  value_in = prev_value;
               end
            end
         end
         SHIFT_DELETE: begin
            // matched cell and those above it close the gap
            if (!lt_ff) begin
               key_in   = next_key;
               value_in = next_value;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

endmodule

`default_nettype wire

>>> design/skvm_group.sv
// first level of the registered match tree: one group of cells
`default_nettype none

module skvm_group (
   input  logic                                              clock,
   input  logic [skvm_pkg::GROUP_SIZE-1:0]                   eq,
   input  logic [skvm_pkg::GROUP_SIZE-1:0][skvm_pkg::KEY_W-1:0] values,
   output logic                                              hit_ff,
   output logic [skvm_pkg::KEY_W-1:0]                        value_ff
);
   import skvm_pkg::*;

   logic             hit_in;
   logic [KEY_W-1:0] value_in;

   // keys are unique, so at most one cell matches and a plain or selects it
   always_comb begin
      hit_in   = 1'b0;
      value_in = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         hit_in   = hit_in | eq[i];
         value_in = value_in | (values[i] & {KEY_W{eq[i]}});
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      value_ff <= value_in;
   end

endmodule

`default_nettype wire
